@@ sv/srg_pkg.sv @@
package srg_pkg;

   localparam int unsigned TABLE_LEN  = 55;
   localparam int unsigned SLOT_W     = $clog2(TABLE_LEN);
   localparam int unsigned WORD_W     = 30;
   localparam int unsigned SEED_W     = 28;
   localparam int unsigned SCATTER    = 21;
   localparam int unsigned TRAIL_INIT = 31;
   localparam int unsigned MIX_OFFSET = 30;
   localparam int unsigned MIX_PASSES = 4;
   localparam int unsigned PASS_W     = $clog2(MIX_PASSES);

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [SLOT_W:0]   slot_sum_type;
   typedef logic [SEED_W-1:0] seed_type;
   typedef logic [PASS_W-1:0] pass_type;

   localparam word_type MOD_BIG    = word_type'(1000000000);
   localparam seed_type SEED_CONST = seed_type'(161803398);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCATTER,
      ST_MIX,
      ST_DRAW,
      ST_WRITE
   } state_type;

   function automatic word_type sub_mod(input word_type a, input word_type b);
      word_type r;
      if (a >= b) begin
         r = a - b;
      end else begin
         r = a - b + MOD_BIG;
      end
      return r;
   endfunction

   // step from 55 back to 1
   function automatic slot_type advance(input slot_type p);
      slot_type r;
      if (p >= slot_type'(TABLE_LEN)) begin
         r = slot_type'(1);
      end else begin
         r = p + slot_type'(1);
      end
      return r;
   endfunction

endpackage

@@ sv/srg_req_if.sv @@
interface srg_req_if import srg_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     cmd;
   seed_type seed;

   modport source (output valid, output cmd, output seed, input ready);
   modport sink   (input valid, input cmd, input seed, output ready);
endinterface

@@ sv/srg_rsp_if.sv @@
interface srg_rsp_if import srg_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type value;
   logic     reseeded;

   modport source (output valid, output value, output reseeded, input ready);
   modport sink   (input valid, input value, input reseeded, output ready);
endinterface

@@ sv/subtractive_random_generator.sv @@
// Lagged subtractive random generator over a 55-word table, modulo one billion.
// req_if carries cmd and seed; an item transfers when valid and ready are high
// at a rising edge. cmd 1 rebuilds the table from seed (values above 161803398
// saturate) and then draws; cmd 0 draws the next value. The first item after
// reset always rebuilds the table, whatever cmd says.
// rsp_if carries one result per item: value in 0..999999999 and reseeded.
// A draw takes the item in ST_IDLE, reads the lead and trail words from the
// table memory in ST_DRAW, and in ST_WRITE writes the difference back and
// loads the output register. A rebuild first does 55 scatter writes and four
// mixing passes of 55 read-modify-write steps, one per cycle on the memory's
// ports. Reset clears the state machine, the pointers, the seeded flag and
// the output valid; the table is not cleared. The output register lets a new
// item be taken while a result waits; when the receiver stalls, a finished
// draw holds in its write step until the output register frees.
module subtractive_random_generator import srg_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   srg_req_if.sink   req_if,
   srg_rsp_if.source rsp_if
);

   word_type  mem [TABLE_LEN];
   word_type  rd_a_ff, rd_b_ff;

   state_type state_ff, state_in;
   slot_type  lead_ff, lead_in;
   slot_type  trail_ff, trail_in;
   logic      seeded_ff, seeded_in;
   logic      reseed_ff, reseed_in;
   word_type  prev_ff, prev_in;
   word_type  cur_ff, cur_in;
   slot_type  pos_ff, pos_in;
   slot_type  cnt_ff, cnt_in;
   pass_type  pass_ff, pass_in;
   logic      mix_wr_vld_ff, mix_wr_vld_in;
   slot_type  mix_wr_addr_ff, mix_wr_addr_in;
   logic      rsp_valid_ff, rsp_valid_in;
   word_type  rsp_value_ff, rsp_value_in;
   logic      rsp_reseeded_ff, rsp_reseeded_in;

   logic      accept;
   logic      need_fill;
   logic      out_free;
   logic      last_scatter;
   logic      last_mix;
   logic      we, re;
   slot_type  wa, ra_a, ra_b;
   word_type  wd;
   word_type  diff;
   seed_type  mag;
   slot_sum_type pos_sum, mix_sum;

   assign accept       = req_if.valid && req_if.ready;
   assign need_fill    = req_if.cmd || !seeded_ff;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign last_scatter = (cnt_ff == slot_type'(TABLE_LEN - 1));
   assign last_mix     = (cnt_ff == slot_type'(TABLE_LEN)) &&
                         (pass_ff == pass_type'(MIX_PASSES - 1));
   assign diff         = sub_mod(rd_a_ff, rd_b_ff);
   assign mag          = (req_if.seed > SEED_CONST) ? SEED_CONST : req_if.seed;
   assign pos_sum      = {1'b0, pos_ff} + slot_sum_type'(SCATTER);
   assign mix_sum      = {1'b0, cnt_ff} + slot_sum_type'(MIX_OFFSET);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = need_fill ? ST_SCATTER : ST_DRAW;
            end
         end
         ST_SCATTER: begin
            if (last_scatter) begin
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            if (last_mix) begin
               state_in = ST_DRAW;
            end
         end
         ST_DRAW: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_if.ready    = (state_ff == ST_IDLE);
      lead_in         = lead_ff;
      trail_in        = trail_ff;
      seeded_in       = seeded_ff;
      reseed_in       = reseed_ff;
      prev_in         = prev_ff;
      cur_in          = cur_ff;
      pos_in          = pos_ff;
      cnt_in          = cnt_ff;
      pass_in         = pass_ff;
      mix_wr_vld_in   = 1'b0;
      mix_wr_addr_in  = mix_wr_addr_ff;
      rsp_valid_in    = rsp_if.ready ? 1'b0 : rsp_valid_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_reseeded_in = rsp_reseeded_ff;
      we              = 1'b0;
      wa              = mix_wr_addr_ff;
      wd              = diff;
      re              = 1'b0;
      ra_a            = lead_ff - slot_type'(1);
      ra_b            = trail_ff - slot_type'(1);

      if (mix_wr_vld_ff) begin
         we = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               reseed_in = need_fill;
               if (need_fill) begin
                  prev_in = word_type'(SEED_CONST - mag);
                  cur_in  = word_type'(1);
                  pos_in  = slot_type'(SCATTER);
                  cnt_in  = '0;
               end else begin
                  lead_in  = advance(lead_ff);
                  trail_in = advance(trail_ff);
               end
            end
         end
         ST_SCATTER: begin
            we     = 1'b1;
            cnt_in = cnt_ff + slot_type'(1);
            if (cnt_ff == '0) begin
               wa = slot_type'(TABLE_LEN - 1);
               wd = prev_ff;
            end else begin
               wa      = pos_ff - slot_type'(1);
               wd      = cur_ff;
               prev_in = cur_ff;
               cur_in  = sub_mod(prev_ff, cur_ff);
               pos_in  = (pos_sum >= slot_sum_type'(TABLE_LEN)) ?
                         slot_type'(pos_sum - slot_sum_type'(TABLE_LEN)) :
                         slot_type'(pos_sum);
            end
            if (last_scatter) begin
               cnt_in  = slot_type'(1);
               pass_in = '0;
            end
         end
         ST_MIX: begin
            re             = 1'b1;
            ra_a           = cnt_ff - slot_type'(1);
            ra_b           = (mix_sum >= slot_sum_type'(TABLE_LEN)) ?
                             slot_type'(mix_sum - slot_sum_type'(TABLE_LEN)) :
                             slot_type'(mix_sum);
            mix_wr_vld_in  = 1'b1;
            mix_wr_addr_in = cnt_ff - slot_type'(1);
            if (cnt_ff == slot_type'(TABLE_LEN)) begin
               cnt_in  = slot_type'(1);
               pass_in = pass_ff + pass_type'(1);
            end else begin
               cnt_in = cnt_ff + slot_type'(1);
            end
            if (last_mix) begin
               lead_in   = advance('0);
               trail_in  = advance(slot_type'(TRAIL_INIT));
               seeded_in = 1'b1;
            end
         end
         ST_DRAW: begin
            re = 1'b1;
         end
         ST_WRITE: begin
            if (out_free) begin
               we              = 1'b1;
               wa              = lead_ff - slot_type'(1);
               wd              = diff;
               rsp_valid_in    = 1'b1;
               rsp_value_in    = diff;
               rsp_reseeded_in = reseed_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (re) begin
         rd_a_ff <= mem[ra_a];
         rd_b_ff <= mem[ra_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         lead_ff       <= '0;
         trail_ff      <= '0;
         seeded_ff     <= 1'b0;
         mix_wr_vld_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lead_ff       <= lead_in;
         trail_ff      <= trail_in;
         seeded_ff     <= seeded_in;
         mix_wr_vld_ff <= mix_wr_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      reseed_ff       <= reseed_in;
      prev_ff         <= prev_in;
      cur_ff          <= cur_in;
      pos_ff          <= pos_in;
      cnt_ff          <= cnt_in;
      pass_ff         <= pass_in;
      mix_wr_addr_ff  <= mix_wr_addr_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_reseeded_ff <= rsp_reseeded_in;
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.value    = rsp_value_ff;
   assign rsp_if.reseeded = rsp_reseeded_ff;

   a_mix_write_follows_read: assert property (@(posedge clock) disable iff (reset)
      mix_wr_vld_ff |-> $past(state_ff == ST_MIX))
      else $error("mixing write without a preceding read");

   a_draw_needs_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAW || state_ff == ST_WRITE) |-> seeded_ff)
      else $error("draw from an unfilled table");

   a_result_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_WRITE))
      else $error("result loaded outside the write step");

   a_pointer_lag: assert property (@(posedge clock) disable iff (reset)
      (seeded_ff && state_ff == ST_IDLE) |->
         (({1'b0, trail_ff} == {1'b0, lead_ff} + slot_sum_type'(TRAIL_INIT)) ||
          ({1'b0, trail_ff} + slot_sum_type'(TABLE_LEN - TRAIL_INIT) == {1'b0, lead_ff})))
      else $error("lead and trail pointers out of step");

   a_single_write_source: assert property (@(posedge clock) disable iff (reset)
      mix_wr_vld_ff |-> (state_ff == ST_MIX || state_ff == ST_DRAW))
      else $error("mixing write overlaps another write");

endmodule
